### hw/rtl/wfaf_pkg.sv
`default_nettype none

package wfaf_pkg;

    localparam int unsigned MAC_W      = 48;
    localparam int unsigned MAC_BYTES  = 6;
    localparam int unsigned PLEN_W     = 3;
    localparam int unsigned FC_W       = 16;
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned RSSI_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned NUM_ADDR   = 3;

    localparam logic [LEN_W-1:0]         FCS_BYTES       = 12'd4;
    localparam logic signed [RSSI_W-1:0] RSSI_THR_RESET  = -8'sd96;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_MAC        = 3'd0,
        REG_OWN_PREFIX     = 3'd1,
        REG_MATCH_MAC      = 3'd2,
        REG_MATCH_PREFIX   = 3'd3,
        REG_RSSI_THRESHOLD = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLASS_MGMT = 2'd0,
        CLASS_CTRL = 2'd1,
        CLASS_DATA = 2'd2,
        CLASS_MISC = 2'd3
    } pkt_class_t;

    typedef enum logic [3:0] {
        SUBTYPE_BAR     = 4'd8,
        SUBTYPE_BA      = 4'd9,
        SUBTYPE_PS_POLL = 4'd10,
        SUBTYPE_RTS     = 4'd11,
        SUBTYPE_CTS     = 4'd12,
        SUBTYPE_ACK     = 4'd13
    } ctrl_subtype_t;

    // bit 0 addr1, bit 1 addr2, bit 2 addr3
    typedef struct packed {
        logic [NUM_ADDR-1:0] own_sel;
        logic [NUM_ADDR-1:0] match_sel;
    } role_sel_t;

    // bit 5 covers the first transmitted byte (bits 47:40)
    function automatic logic [MAC_BYTES-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        logic [MAC_BYTES-1:0] m;
        begin
            unique case (len)
                3'd0:    m = 6'b000000;
                3'd1:    m = 6'b100000;
                3'd2:    m = 6'b110000;
                3'd3:    m = 6'b111000;
                3'd4:    m = 6'b111100;
                3'd5:    m = 6'b111110;
                default: m = 6'b111111;
            endcase
            return m;
        end
    endfunction

    function automatic logic [MAC_BYTES-1:0] byte_eq(input logic [MAC_W-1:0] a,
                                                     input logic [MAC_W-1:0] b);
        logic [MAC_BYTES-1:0] e;
        begin
            for (int k = 0; k < MAC_BYTES; k++)
            begin
                e[k] = (a[8*k +: 8] == b[8*k +: 8]);
            end
            return e;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/wfaf_if.sv
`default_nettype none

interface wfaf_hdr_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            pkt_class;
    logic                                  rx_error;
    logic [wfaf_pkg::FC_W-1:0]             frame_control;
    logic signed [wfaf_pkg::RSSI_W-1:0]    rssi;
    logic [wfaf_pkg::MAC_W-1:0]            addr1;
    logic [wfaf_pkg::MAC_W-1:0]            addr2;
    logic [wfaf_pkg::MAC_W-1:0]            addr3;
    logic [wfaf_pkg::LEN_W-1:0]            frame_length;

    modport source (output valid, pkt_class, rx_error, frame_control, rssi,
                    addr1, addr2, addr3, frame_length, input ready);
    modport sink   (input valid, pkt_class, rx_error, frame_control, rssi,
                    addr1, addr2, addr3, frame_length, output ready);
endinterface

interface wfaf_res_if;
    logic                          valid;
    logic                          ready;
    logic                          accept;
    logic                          own_hit;
    logic                          match_hit;
    logic                          rssi_ok;
    logic [wfaf_pkg::LEN_W-1:0]    trimmed_length;

    modport source (output valid, accept, own_hit, match_hit, rssi_ok, trimmed_length,
                    input ready);
    modport sink   (input valid, accept, own_hit, match_hit, rssi_ok, trimmed_length,
                    output ready);
endinterface

interface wfaf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wfaf_pkg::CFG_IDX_W-1:0]    index;
    logic [wfaf_pkg::MAC_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/wfaf_role_dec.sv
`default_nettype none

module wfaf_role_dec
(
    input  wire logic [1:0]                     pkt_class,
    input  wire logic                           rx_error,
    input  wire logic [wfaf_pkg::FC_W-1:0]      frame_control,
    output wfaf_pkg::role_sel_t                 sel
);

    logic [3:0] subtype;
    logic       to_ds;
    logic       from_ds;

    assign subtype = frame_control[7:4];
    assign to_ds   = frame_control[8];
    assign from_ds = frame_control[9];

    always_comb
    begin
        sel.own_sel   = 3'b000;
        sel.match_sel = 3'b000;
        if (!rx_error)
        begin
            unique case (wfaf_pkg::pkt_class_t'(pkt_class))
                wfaf_pkg::CLASS_MGMT:
                begin
                    sel.own_sel   = 3'b111;
                    sel.match_sel = 3'b011;
                end
                wfaf_pkg::CLASS_DATA:
                begin
                    priority if (from_ds && !to_ds)
                    begin
                        sel.own_sel   = 3'b101;
                        sel.match_sel = 3'b100;
                    end
                    else if (to_ds && !from_ds)
                    begin
                        sel.own_sel   = 3'b110;
                        sel.match_sel = 3'b010;
                    end
                    else
                    begin
                        sel.own_sel   = 3'b011;
                        sel.match_sel = 3'b010;
                    end
                end
                wfaf_pkg::CLASS_CTRL:
                begin
                    unique case (subtype)
                        wfaf_pkg::SUBTYPE_BAR, wfaf_pkg::SUBTYPE_BA, wfaf_pkg::SUBTYPE_RTS:
                        begin
                            sel.own_sel   = 3'b011;
                            sel.match_sel = 3'b010;
                        end
                        wfaf_pkg::SUBTYPE_PS_POLL:
                        begin
                            sel.own_sel   = 3'b010;
                            sel.match_sel = 3'b010;
                        end
                        wfaf_pkg::SUBTYPE_CTS, wfaf_pkg::SUBTYPE_ACK:
                        begin
                            sel.own_sel   = 3'b001;
                            sel.match_sel = 3'b001;
                        end
                        default:
                        begin
                            sel.own_sel   = 3'b000;
                            sel.match_sel = 3'b000;
                        end
                    endcase
                end
                default:
                begin
                    sel.own_sel   = 3'b000;
                    sel.match_sel = 3'b000;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/wlan_frame_address_filter.sv
`default_nettype none

// Each header transaction gives one result, registered through every stage in turn.
// Throughput: one header per cycle unless res stalls; each of the three stages
// advances when it is empty or the stage after it moves, so bubbles are filled while
// the output waits. Reset clears all stage valid bits and loads the config registers
// with their defaults (addresses 0, prefix lengths 0, RSSI threshold -96 dBm).
module wlan_frame_address_filter
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    wfaf_cfg_if.sink    cfg,
    wfaf_hdr_if.sink    hdr,
    wfaf_res_if.source  res
);

    localparam int unsigned NB = wfaf_pkg::MAC_BYTES;

    // configuration
    logic [wfaf_pkg::MAC_W-1:0]          own_mac_reg;
    logic [wfaf_pkg::PLEN_W-1:0]         own_plen_reg;
    logic [wfaf_pkg::MAC_W-1:0]          match_mac_reg;
    logic [wfaf_pkg::PLEN_W-1:0]         match_plen_reg;
    logic signed [wfaf_pkg::RSSI_W-1:0]  rssi_thr_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg    <= '0;
            own_plen_reg   <= '0;
            match_mac_reg  <= '0;
            match_plen_reg <= '0;
            rssi_thr_reg   <= wfaf_pkg::RSSI_THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                wfaf_pkg::REG_OWN_MAC:        own_mac_reg    <= cfg.data;
                wfaf_pkg::REG_OWN_PREFIX:     own_plen_reg   <= cfg.data[wfaf_pkg::PLEN_W-1:0];
                wfaf_pkg::REG_MATCH_MAC:      match_mac_reg  <= cfg.data;
                wfaf_pkg::REG_MATCH_PREFIX:   match_plen_reg <= cfg.data[wfaf_pkg::PLEN_W-1:0];
                wfaf_pkg::REG_RSSI_THRESHOLD: rssi_thr_reg   <= cfg.data[wfaf_pkg::RSSI_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3      = !v3_reg || res.ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign hdr.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= hdr.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // stage 1: byte compares, RSSI rule, length trim
    logic [NB-1:0] own_eq_next   [wfaf_pkg::NUM_ADDR];
    logic [NB-1:0] match_eq_next [wfaf_pkg::NUM_ADDR];
    logic [NB-1:0] own_eq_reg    [wfaf_pkg::NUM_ADDR];
    logic [NB-1:0] match_eq_reg  [wfaf_pkg::NUM_ADDR];
    logic                        rssi_ok_next, rssi_ok1_reg;
    logic [wfaf_pkg::LEN_W-1:0]  trim_next, trim1_reg;
    logic [1:0]                  class1_reg;
    logic                        err1_reg;
    logic [wfaf_pkg::FC_W-1:0]   fc1_reg;

    always_comb
    begin
        own_eq_next[0]   = wfaf_pkg::byte_eq(hdr.addr1, own_mac_reg);
        own_eq_next[1]   = wfaf_pkg::byte_eq(hdr.addr2, own_mac_reg);
        own_eq_next[2]   = wfaf_pkg::byte_eq(hdr.addr3, own_mac_reg);
        match_eq_next[0] = wfaf_pkg::byte_eq(hdr.addr1, match_mac_reg);
        match_eq_next[1] = wfaf_pkg::byte_eq(hdr.addr2, match_mac_reg);
        match_eq_next[2] = wfaf_pkg::byte_eq(hdr.addr3, match_mac_reg);
        rssi_ok_next = (rssi_thr_reg == '0) ||
                       (rssi_thr_reg[wfaf_pkg::RSSI_W-1] && (hdr.rssi >= rssi_thr_reg));
        trim_next = (hdr.frame_length >= wfaf_pkg::FCS_BYTES) ?
                    (hdr.frame_length - wfaf_pkg::FCS_BYTES) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            own_eq_reg   <= own_eq_next;
            match_eq_reg <= match_eq_next;
            rssi_ok1_reg <= rssi_ok_next;
            trim1_reg    <= trim_next;
            class1_reg   <= hdr.pkt_class;
            err1_reg     <= hdr.rx_error;
            fc1_reg      <= hdr.frame_control;
        end
    end

    // stage 2: prefix hits per address, role selection
    logic [NB-1:0]                   own_mask, match_mask;
    logic [wfaf_pkg::NUM_ADDR-1:0]   own_addr_hit_next, match_addr_hit_next;
    logic [wfaf_pkg::NUM_ADDR-1:0]   own_addr_hit_reg, match_addr_hit_reg;
    wfaf_pkg::role_sel_t             sel_next, sel_reg;
    logic                            rssi_ok2_reg;
    logic [wfaf_pkg::LEN_W-1:0]      trim2_reg;

    assign own_mask   = wfaf_pkg::prefix_mask(own_plen_reg);
    assign match_mask = wfaf_pkg::prefix_mask(match_plen_reg);

    always_comb
    begin
        for (int a = 0; a < wfaf_pkg::NUM_ADDR; a++)
        begin
            own_addr_hit_next[a]   = &(own_eq_reg[a] | ~own_mask);
            match_addr_hit_next[a] = &(match_eq_reg[a] | ~match_mask);
        end
    end

    wfaf_role_dec u_role_dec
    (
        .pkt_class     (class1_reg),
        .rx_error      (err1_reg),
        .frame_control (fc1_reg),
        .sel           (sel_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            own_addr_hit_reg   <= own_addr_hit_next;
            match_addr_hit_reg <= match_addr_hit_next;
            sel_reg            <= sel_next;
            rssi_ok2_reg       <= rssi_ok1_reg;
            trim2_reg          <= trim1_reg;
        end
    end

    // stage 3: combine into the output register
    logic                        own_next, match_next;
    logic                        accept_reg, own_reg, match_reg, rssi_ok3_reg;
    logic [wfaf_pkg::LEN_W-1:0]  trim3_reg;

    assign own_next   = |(own_addr_hit_reg & sel_reg.own_sel);
    assign match_next = |(match_addr_hit_reg & sel_reg.match_sel);

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            // match is forced low for errored or misc frames by the role decoder
            accept_reg   <= rssi_ok2_reg && !own_next && match_next;
            own_reg      <= own_next;
            match_reg    <= match_next;
            rssi_ok3_reg <= rssi_ok2_reg;
            trim3_reg    <= trim2_reg;
        end
    end

    assign res.valid          = v3_reg;
    assign res.accept         = accept_reg;
    assign res.own_hit        = own_reg;
    assign res.match_hit      = match_reg;
    assign res.rssi_ok        = rssi_ok3_reg;
    assign res.trimmed_length = trim3_reg;

endmodule

`default_nettype wire
